// ===== sv/ydd_pkg.sv =====
package ydd_pkg;

	localparam int FRAC_BITS  = 16;
	localparam int VAL_W      = 32;
	localparam int N_W        = 35;
	localparam int MAG_W      = 33;
	localparam int PROD_W     = 64;
	localparam int COORD_W    = 30;
	localparam int LABEL_W    = 7;
	localparam int SCORE_W    = 17;
	localparam int THR_W      = 17;
	localparam int COUNT_W    = 8;
	localparam int SCALE_W    = 31;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 31;

	// fixed row layout
	localparam int POS_CENTRE_X    = 0;
	localparam int POS_CENTRE_Y    = 1;
	localparam int POS_WIDTH       = 2;
	localparam int POS_HEIGHT      = 3;
	localparam int POS_OBJECTNESS  = 4;
	localparam int FIRST_CLASS_POS = 5;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_SCORE_THRESHOLD = 3'd0,
		REG_CLASS_COUNT     = 3'd1,
		REG_PAD_LEFT        = 3'd2,
		REG_PAD_TOP         = 3'd3,
		REG_INVERSE_SCALE   = 3'd4,
		REG_X_LIMIT         = 3'd5,
		REG_Y_LIMIT         = 3'd6
	} cfg_reg_t;

	localparam logic [THR_W-1:0]   RST_SCORE_THRESHOLD = 17'd32768;
	localparam logic [COUNT_W-1:0] RST_CLASS_COUNT     = 8'd80;
	localparam logic [COORD_W-1:0] RST_PAD             = 30'd0;
	localparam logic [SCALE_W-1:0] RST_INVERSE_SCALE   = 31'd65536;
	localparam logic [COORD_W-1:0] RST_LIMIT           = 30'd41877504;

	typedef struct packed {
		logic [THR_W-1:0]   score_threshold;
		logic [COUNT_W-1:0] class_count;
		logic [COORD_W-1:0] pad_left;
		logic [COORD_W-1:0] pad_top;
		logic [SCALE_W-1:0] inverse_scale;
		logic [COORD_W-1:0] x_limit;
		logic [COORD_W-1:0] y_limit;
	} cfg_t;

	// one finished row, corners still in signed half-units
	typedef struct packed {
		logic signed [N_W-1:0]   n_left;
		logic signed [N_W-1:0]   n_top;
		logic signed [N_W-1:0]   n_right;
		logic signed [N_W-1:0]   n_bottom;
		logic signed [VAL_W-1:0] objectness;
		logic signed [VAL_W-1:0] best_score;
		logic [LABEL_W-1:0]      label;
	} row_t;

endpackage

// ===== sv/yolo_detection_decode_core.sv =====
// a row end passes the row register, the product registers, then the result register
// one item per cycle when not stalled; at most one result per row of 5 + class_count items
// the row accumulator sees every item; only the row end enters the two math stages
// the confidence and corner multipliers sit in their own stage, registered before the compare
// reset (arst_n low, asynchronous): row position at zero, pipeline empty, registers at defaults
module yolo_detection_decode_core #(
	parameter int MAX_CLASSES = 128
) (
	input  logic                           clk,
	input  logic                           arst_n,
	// input items
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic [ydd_pkg::VAL_W-1:0]      row_value,
	// result items
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic [ydd_pkg::COORD_W-1:0]    left_x,
	output logic [ydd_pkg::COORD_W-1:0]    top_y,
	output logic [ydd_pkg::COORD_W-1:0]    right_x,
	output logic [ydd_pkg::COORD_W-1:0]    bottom_y,
	output logic [ydd_pkg::LABEL_W-1:0]    class_label,
	output logic [ydd_pkg::SCORE_W-1:0]    box_score,
	// configuration writes
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [ydd_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [ydd_pkg::CFG_DATA_W-1:0] cfg_data
);
	import ydd_pkg::*;

	cfg_t cfg_q;
	row_t row;
	logic item_accept;
	logic row_done;
	logic row_stall;

	// register file always takes a write
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.score_threshold <= RST_SCORE_THRESHOLD;
			cfg_q.class_count     <= RST_CLASS_COUNT;
			cfg_q.pad_left        <= RST_PAD;
			cfg_q.pad_top         <= RST_PAD;
			cfg_q.inverse_scale   <= RST_INVERSE_SCALE;
			cfg_q.x_limit         <= RST_LIMIT;
			cfg_q.y_limit         <= RST_LIMIT;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_SCORE_THRESHOLD: cfg_q.score_threshold <= cfg_data[THR_W-1:0];
				REG_CLASS_COUNT:     cfg_q.class_count     <= cfg_data[COUNT_W-1:0];
				REG_PAD_LEFT:        cfg_q.pad_left        <= cfg_data[COORD_W-1:0];
				REG_PAD_TOP:         cfg_q.pad_top         <= cfg_data[COORD_W-1:0];
				REG_INVERSE_SCALE:   cfg_q.inverse_scale   <= cfg_data[SCALE_W-1:0];
				REG_X_LIMIT:         cfg_q.x_limit         <= cfg_data[COORD_W-1:0];
				REG_Y_LIMIT:         cfg_q.y_limit         <= cfg_data[COORD_W-1:0];
				default: ; // writes past the last register are dropped
			endcase
		end
	end

	// any item is held off while stage one holds a row that cannot move on into stage two
	assign in_stall    = row_stall;
	assign item_accept = in_valid && !in_stall;

	// per-item tracking: box values, running best class
	ydd_row_accum #(
		.MAX_CLASSES (MAX_CLASSES)
	) u_accum (
		.clk         (clk),
		.arst_n      (arst_n),
		.item_accept (item_accept),
		.row_value   (row_value),
		.cfg         (cfg_q),
		.row_done    (row_done),
		.row         (row)
	);

	// row end: multiply, threshold, scale, clamp, result register
	ydd_box_calc u_box (
		.clk         (clk),
		.arst_n      (arst_n),
		.row_valid   (row_done),
		.row         (row),
		.cfg         (cfg_q),
		.row_stall   (row_stall),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.left_x      (left_x),
		.top_y       (top_y),
		.right_x     (right_x),
		.bottom_y    (bottom_y),
		.class_label (class_label),
		.box_score   (box_score)
	);

endmodule

// ===== sv/ydd_row_accum.sv =====
module ydd_row_accum #(
	parameter int MAX_CLASSES = 128
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      item_accept,
	input  logic [ydd_pkg::VAL_W-1:0] row_value,
	input  ydd_pkg::cfg_t             cfg,
	output logic                      row_done,
	output ydd_pkg::row_t             row
);
	import ydd_pkg::*;

	localparam int POS_W = $clog2(MAX_CLASSES + FIRST_CLASS_POS);
	localparam int CNT_W = $clog2(MAX_CLASSES + 1) > 0 ? $clog2(MAX_CLASSES + 1) : 1;
	localparam int IDX_W = MAX_CLASSES > 1 ? $clog2(MAX_CLASSES) : 1;

	logic [POS_W-1:0]        pos_q;
	logic signed [VAL_W-1:0] cx_q, cy_q, w_q, h_q, obj_q, best_q;
	logic [IDX_W-1:0]        idx_q;

	logic [CNT_W-1:0]        class_eff;
	logic [POS_W:0]          end_pos;
	logic                    is_class, is_first, last;
	logic signed [VAL_W-1:0] best_nxt;
	logic [IDX_W-1:0]        idx_nxt;

	always_comb begin
		if (cfg.class_count == '0) begin
			class_eff = CNT_W'(1);
		end else if (int'(cfg.class_count) > MAX_CLASSES) begin
			class_eff = CNT_W'(MAX_CLASSES);
		end else begin
			class_eff = CNT_W'(cfg.class_count);
		end
	end

	// row ends once position reaches 4 + count
	assign end_pos  = (POS_W+1)'(class_eff) + (POS_W+1)'(FIRST_CLASS_POS - 1);
	assign is_class = pos_q >= POS_W'(FIRST_CLASS_POS);
	assign is_first = pos_q == POS_W'(FIRST_CLASS_POS);
	assign last     = is_class && ({1'b0, pos_q} >= end_pos);

	always_comb begin
		best_nxt = best_q;
		idx_nxt  = idx_q;
		if (is_first) begin
			best_nxt = $signed(row_value);
			idx_nxt  = '0;
		end else if (is_class && ($signed(row_value) > best_q)) begin
			best_nxt = $signed(row_value);
			idx_nxt  = IDX_W'(pos_q - POS_W'(FIRST_CLASS_POS));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
		end else if (item_accept) begin
			pos_q <= last ? '0 : pos_q + POS_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (item_accept) begin
			case (pos_q)
				POS_W'(POS_CENTRE_X):   cx_q  <= $signed(row_value);
				POS_W'(POS_CENTRE_Y):   cy_q  <= $signed(row_value);
				POS_W'(POS_WIDTH):      w_q   <= $signed(row_value);
				POS_W'(POS_HEIGHT):     h_q   <= $signed(row_value);
				POS_W'(POS_OBJECTNESS): obj_q <= $signed(row_value);
				default: begin
					best_q <= best_nxt;
					idx_q  <= idx_nxt;
				end
			endcase
		end
	end

	// corners in half-units: 2*c -/+ size - 2*pad
	logic signed [N_W-1:0] cx2, cy2, w_ext, h_ext, px2, py2;

	assign cx2   = {{(N_W-VAL_W-1){cx_q[VAL_W-1]}}, cx_q, 1'b0};
	assign cy2   = {{(N_W-VAL_W-1){cy_q[VAL_W-1]}}, cy_q, 1'b0};
	assign w_ext = {{(N_W-VAL_W){w_q[VAL_W-1]}}, w_q};
	assign h_ext = {{(N_W-VAL_W){h_q[VAL_W-1]}}, h_q};
	assign px2   = {{(N_W-COORD_W-1){1'b0}}, cfg.pad_left, 1'b0};
	assign py2   = {{(N_W-COORD_W-1){1'b0}}, cfg.pad_top, 1'b0};

	always_comb begin
		row.n_left     = cx2 - w_ext - px2;
		row.n_top      = cy2 - h_ext - py2;
		row.n_right    = cx2 + w_ext - px2;
		row.n_bottom   = cy2 + h_ext - py2;
		row.objectness = obj_q;
		row.best_score = best_nxt;
		row.label      = LABEL_W'(idx_nxt);
	end

	assign row_done = item_accept && last;

endmodule

// ===== sv/ydd_box_calc.sv =====
module ydd_box_calc (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        row_valid,
	input  ydd_pkg::row_t               row,
	input  ydd_pkg::cfg_t               cfg,
	output logic                        row_stall,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic [ydd_pkg::COORD_W-1:0] left_x,
	output logic [ydd_pkg::COORD_W-1:0] top_y,
	output logic [ydd_pkg::COORD_W-1:0] right_x,
	output logic [ydd_pkg::COORD_W-1:0] bottom_y,
	output logic [ydd_pkg::LABEL_W-1:0] class_label,
	output logic [ydd_pkg::SCORE_W-1:0] box_score
);
	import ydd_pkg::*;

	function automatic logic [COORD_W-1:0] clamp_corner(
		input logic              positive,
		input logic [PROD_W-1:0] prod,
		input logic [COORD_W-1:0] limit
	);
		logic [PROD_W-1:0] v;
		v = prod >> (FRAC_BITS + 1);
		if (!positive) begin
			return '0;
		end else if (v > PROD_W'(limit)) begin
			return limit;
		end else begin
			return COORD_W'(v);
		end
	endfunction

	logic                     valid_s1, valid_s2, out_valid_q;
	row_t                     row_s1;
	logic [3:0]               pos_s2;
	logic [3:0][PROD_W-1:0]   prod_s2;
	logic signed [PROD_W-1:0] conf_s2;
	logic [LABEL_W-1:0]       label_s2;

	logic                     pass, out_free, s2_go, s2_free, s1_free;
	logic [PROD_W-1:0]        thr_wide, score_full, score_sat;

	assign thr_wide = PROD_W'(cfg.score_threshold) << FRAC_BITS;
	assign pass     = conf_s2 > $signed(thr_wide);

	assign out_free  = !out_valid_q || !out_stall;
	assign s2_go     = valid_s2 && (!pass || out_free);
	assign s2_free   = !valid_s2 || s2_go;
	assign s1_free   = !valid_s1 || s2_free;
	assign row_stall = !s1_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (s1_free)
				valid_s1 <= row_valid;
			if (s2_free)
				valid_s2 <= valid_s1;
			if (s2_go && pass)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_free && row_valid)
			row_s1 <= row;
		if (s2_free && valid_s1) begin
			pos_s2[0]  <= $signed(row_s1.n_left) > 0;
			pos_s2[1]  <= $signed(row_s1.n_top) > 0;
			pos_s2[2]  <= $signed(row_s1.n_right) > 0;
			pos_s2[3]  <= $signed(row_s1.n_bottom) > 0;
			prod_s2[0] <= PROD_W'(row_s1.n_left[MAG_W-1:0]) * PROD_W'(cfg.inverse_scale);
			prod_s2[1] <= PROD_W'(row_s1.n_top[MAG_W-1:0]) * PROD_W'(cfg.inverse_scale);
			prod_s2[2] <= PROD_W'(row_s1.n_right[MAG_W-1:0]) * PROD_W'(cfg.inverse_scale);
			prod_s2[3] <= PROD_W'(row_s1.n_bottom[MAG_W-1:0]) * PROD_W'(cfg.inverse_scale);
			conf_s2    <= PROD_W'($signed(row_s1.objectness)) * PROD_W'($signed(row_s1.best_score));
			label_s2   <= row_s1.label;
		end
	end

	// score saturates at one
	assign score_full = PROD_W'(conf_s2) >> FRAC_BITS;
	assign score_sat  = (score_full > (PROD_W'(1) << FRAC_BITS)) ?
		(PROD_W'(1) << FRAC_BITS) : score_full;

	always_ff @(posedge clk) begin
		if (s2_go && pass) begin
			left_x      <= clamp_corner(pos_s2[0], prod_s2[0], cfg.x_limit);
			top_y       <= clamp_corner(pos_s2[1], prod_s2[1], cfg.y_limit);
			right_x     <= clamp_corner(pos_s2[2], prod_s2[2], cfg.x_limit);
			bottom_y    <= clamp_corner(pos_s2[3], prod_s2[3], cfg.y_limit);
			class_label <= label_s2;
			box_score   <= SCORE_W'(score_sat);
		end
	end

	assign out_valid = out_valid_q;

endmodule

// ===== sv/ydd_checker.sv =====
module ydd_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        in_stall,
	input logic                        out_valid,
	input logic                        out_stall,
	input logic [ydd_pkg::COORD_W-1:0] left_x,
	input logic [ydd_pkg::COORD_W-1:0] top_y,
	input logic [ydd_pkg::COORD_W-1:0] right_x,
	input logic [ydd_pkg::COORD_W-1:0] bottom_y,
	input logic [ydd_pkg::LABEL_W-1:0] class_label,
	input logic [ydd_pkg::SCORE_W-1:0] box_score
);
	import ydd_pkg::*;

	// a stalled result item holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(left_x) && $stable(top_y)
			&& $stable(right_x) && $stable(bottom_y) && $stable(class_label)
			&& $stable(box_score))
		else $error("result item changed while stalled");

	// score never above one
	a_score_sat: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> box_score <= SCORE_W'(1 << FRAC_BITS))
		else $error("box score above saturation");

	// input is held off only behind an occupied result register
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid)
		else $error("input stalled with empty result register");

	// nothing comes out right after reset
	a_reset_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!$past(arst_n) |-> !out_valid)
		else $error("result item right after reset");

endmodule

bind yolo_detection_decode_core ydd_checker u_ydd_checker (.*);
